// ----- rtl/lhq_pkg.sv -----
// shared types, constants and a helper for the log2 latency histogram
package lhq_pkg;

  localparam int NUM_BUCKETS = 32;
  localparam int BIDX_W      = $clog2(NUM_BUCKETS);
  localparam int BOUND_SHIFT = 10;
  localparam int FRAC_W      = 17;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);

  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);
  localparam logic [BIDX_W-1:0] LAST_BUCKET = BIDX_W'(NUM_BUCKETS - 1);

  typedef enum logic {
    REQ_RECORD = 1'b0,
    REQ_QUERY  = 1'b1
  } req_e;

  typedef struct packed {
    req_e              kind;
    logic [BIDX_W-1:0] bucket;
    logic [63:0]       latency;
    logic [FRAC_W-1:0] frac;
  } entry_t;

  function automatic logic [63:0] bound_of(input logic [BIDX_W-1:0] idx);
    logic [63:0] b;
    if (32'(idx) + 1 >= NUM_BUCKETS) begin
      b = '1;
    end else begin
      b = 64'(1) << (32'(idx) + BOUND_SHIFT);
    end
    return b;
  endfunction

endpackage

// ----- rtl/lhq_front.sv -----
// front end: takes input beats, finds the bucket and saturates the quantile
module lhq_front (
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   req_type_i,
  input  logic [63:0]            latency_ns_i,
  input  logic [16:0]            quantile_frac_i,
  input  logic                   q_full_i,
  output logic                   push_o,
  output lhq_pkg::entry_t        push_entry_o
);
  import lhq_pkg::*;

  logic [BIDX_W-1:0] bucket;
  logic [FRAC_W-1:0] frac_sat;

  always_comb begin
    bucket = '0;
    for (int i = 0; i < NUM_BUCKETS - 1; i++) begin
      if ((latency_ns_i >> (i + BOUND_SHIFT)) != 64'd0) begin
        bucket = BIDX_W'(i + 1);
      end
    end
  end

  assign frac_sat = (quantile_frac_i > FRAC_ONE) ? FRAC_ONE : quantile_frac_i;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    push_entry_o.kind    = req_type_i ? REQ_QUERY : REQ_RECORD;
    push_entry_o.bucket  = bucket;
    push_entry_o.latency = latency_ns_i;
    push_entry_o.frac    = frac_sat;
  end

endmodule

// ----- rtl/lhq_queue.sv -----
// short fifo between the front end and the histogram engine
module lhq_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lhq_pkg::entry_t push_entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output lhq_pkg::entry_t head_o
);
  import lhq_pkg::*;

  entry_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign full_o       = (count_q == (QPTR_W + 1)'(QDEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (QPTR_W + 1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ----- rtl/lhq_back.sv -----
// histogram engine: bucket counters, totals, quantile target and bucket scan
module lhq_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  lhq_pkg::entry_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [63:0]     quantile_bound_ns_o,
  output logic [63:0]     total_samples_o,
  output logic [63:0]     latency_sum_ns_o
);
  import lhq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_TGT,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e            state_q;
  logic [63:0]       counts_q [NUM_BUCKETS];
  logic [63:0]       total_q, sum_q;
  logic [FRAC_W-1:0] frac_q;
  logic [63:0]       prod_hi_q;
  logic [32:0]       prod_lo_q;
  logic [63:0]       target_q, seen_q, bound_q;
  logic [BIDX_W-1:0] scan_idx_q;
  logic              out_valid_q;
  logic [63:0]       out_bound_q, out_total_q, out_sum_q;

  logic [BIDX_W-1:0] rd_idx;
  logic [63:0]       rd_count, seen_d;
  logic [64:0]       prod_hi;
  logic              hit, out_free, out_load;

  assign pop_o    = (state_q == ST_IDLE) && head_valid_i;
  assign rd_idx   = (state_q == ST_SCAN) ? scan_idx_q : head_i.bucket;
  assign rd_count = counts_q[rd_idx];
  assign seen_d   = seen_q + rd_count;
  assign hit      = (seen_d > target_q) || (seen_d == total_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == ST_DONE) && out_free;
  assign prod_hi  = total_q[63:16] * frac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      total_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        counts_q[i] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (head_valid_i) begin
            if (head_i.kind == REQ_RECORD) begin
              counts_q[head_i.bucket] <= rd_count + 64'd1;
              total_q <= total_q + 64'd1;
              sum_q   <= sum_q + head_i.latency;
            end else if (total_q == 64'd0) begin
              bound_q <= '0;
              state_q <= ST_DONE;
            end else begin
              frac_q  <= head_i.frac;
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          prod_hi_q <= prod_hi[63:0];
          prod_lo_q <= total_q[15:0] * frac_q;
          state_q   <= ST_TGT;
        end
        ST_TGT: begin
          target_q   <= prod_hi_q + 64'(prod_lo_q[32:16]);
          seen_q     <= '0;
          scan_idx_q <= '0;
          state_q    <= ST_SCAN;
        end
        ST_SCAN: begin
          seen_q <= seen_d;
          if (hit || scan_idx_q == LAST_BUCKET) begin
            bound_q <= bound_of(scan_idx_q);
            state_q <= ST_DONE;
          end else begin
            scan_idx_q <= scan_idx_q + BIDX_W'(1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_bound_q <= bound_q;
            out_total_q <= total_q;
            out_sum_q   <= sum_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign quantile_bound_ns_o = out_bound_q;
  assign total_samples_o     = out_total_q;
  assign latency_sum_ns_o    = out_sum_q;

endmodule

// ----- rtl/log2_latency_histogram_quantile.sv -----
// top level of the log2 bucket latency histogram with quantile lookup
// Record beats are sustained at one per clock while the queue is not full: the front end
// picks the bucket with a leading one search and a four entry queue feeds the engine, which
// updates one counter, the sample count and the sum per cycle and gives no result. A query
// holds the engine through the pop, the multiply, forming the target, a scan through the
// bucket counters one per cycle up to the bucket where it stops (index 0 to NUM_BUCKETS-1)
// and the load of the output register; an empty histogram goes from the pop straight to the
// output load. Records queue up behind a query while it scans. Counters clear at reset.
module log2_latency_histogram_quantile (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [63:0] latency_ns_i,
  input  logic [16:0] quantile_frac_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] quantile_bound_ns_o,
  output logic [63:0] total_samples_o,
  output logic [63:0] latency_sum_ns_o
);
  import lhq_pkg::*;

  logic   q_full, push, pop, head_valid;
  entry_t push_entry, head;

  lhq_front u_front (
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .latency_ns_i    (latency_ns_i),
    .quantile_frac_i (quantile_frac_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .push_entry_o    (push_entry)
  );

  lhq_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  lhq_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .head_valid_i        (head_valid),
    .head_i              (head),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .quantile_bound_ns_o (quantile_bound_ns_o),
    .total_samples_o     (total_samples_o),
    .latency_sum_ns_o    (latency_sum_ns_o)
  );

endmodule
